[rtl/gpsc_pkg.sv]
// package for the grid pattern search controller
// holds sizes, request codes and shared types; no dependencies
package gpsc_pkg;

  localparam int NUM_VARS   = 4;
  localparam int MAX_RADIUS = 16;
  localparam int VAR_W      = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_REPLY = 2'd2;

  localparam logic [32:0] NONE_BEST = 33'h0_8000_0000;

  // command to the arithmetic unit
  typedef enum logic [1:0] {
    OP_CAND  = 2'd0,
    OP_SCALE = 2'd1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] base;
    logic signed [6:0]  offs;
    logic [30:0]        step;
    logic [15:0]        factor;
  } alu_req_t;

endpackage

[rtl/gpsc_alu.sv]
// shared multiply unit: candidate value with saturation, or step scaling
// registered result, ready in the cycle after the operands; uses gpsc_pkg
module gpsc_alu
  import gpsc_pkg::*;
(
  input  logic        clk,
  input  alu_req_t    req,
  output logic [31:0] result
);

  logic signed [31:0] a;
  logic signed [16:0] b;
  logic signed [47:0] prod;
  logic signed [47:0] sum;

  // one 32x17 multiplier shared by both ops
  always_comb begin
    a = {1'b0, req.step};
    if (req.op == OP_SCALE) begin
      b = {1'b0, req.factor};
    end else begin
      b = {{10{req.offs[6]}}, req.offs};
    end
    prod = a * b;
    sum  = prod + {{16{req.base[31]}}, req.base};
  end

  always_ff @(posedge clk) begin
    if (req.op == OP_SCALE) begin
      result <= {1'b0, prod[46:16]};
    end else if (sum > 48'sd2147483647) begin
      result <= 32'h7fff_ffff;
    end else if (sum < -48'sd2147483648) begin
      result <= 32'h8000_0000;
    end else begin
      result <= sum[31:0];
    end
  end

endmodule

[rtl/grid_pattern_search_controller_top.sv]
// grid pattern search controller: sequencer, stores and result streaming
// start beat: busy through S_CAND and S_WAITC, then S_EMIT streams the vector, one per cycle;
// reply beat: S_WAITJ and S_JUDGE first; a scaling round adds S_SCALE; the final point
// goes from S_JUDGE straight to S_EMIT; loads keep busy low; synchronous active-high reset
// clears stores, best value and control; results can't stall
module grid_pattern_search_controller_top
  import gpsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [2:0]         var_index,
  input  logic signed [31:0] start_value,
  input  logic [30:0]        max_step,
  input  logic [4:0]         radius,
  input  logic [15:0]        shrink_factor,
  input  logic signed [31:0] objective,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  output logic               strobe,
  output logic               kind,
  output logic [2:0]         elem_index,
  output logic signed [31:0] elem_value,
  output logic signed [32:0] best_so_far,
  output logic               last
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_JUDGE  = 7'b0000010,
    S_WAITJ  = 7'b0000100,
    S_SCALE  = 7'b0001000,
    S_CAND   = 7'b0010000,
    S_WAITC  = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state;

  logic [31:0]        point [NUM_VARS];
  logic [30:0]        step_init [NUM_VARS];
  logic [30:0]        step_now [NUM_VARS];
  logic [4:0]         radius_store [NUM_VARS];
  logic [15:0]        factor_store [NUM_VARS];
  logic [31:0]        base_value;
  logic [5:0]         offset_now;
  logic [VAR_W-1:0]   current_var;
  logic               improved_flag;
  logic [7:0]         rounds_done;
  logic signed [32:0] best_objective;
  logic               running;
  logic [7:0]         scaling_rounds;
  logic signed [31:0] obj_hold;
  logic signed [32:0] obj_ext;
  logic               better;
  logic               final_out;
  logic [VAR_W-1:0]   idx;
  logic               accept;

  alu_req_t    areq;
  logic [31:0] ares;

  gpsc_alu u_alu (.clk(clk), .req(areq), .result(ares));

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // reply compared as a signed 33-bit value
  assign obj_ext = {obj_hold[31], obj_hold};
  assign better  = (obj_ext < best_objective);

  // multiplier operands chosen by state
  always_comb begin
    areq.op     = (state == S_SCALE) ? OP_SCALE : OP_CAND;
    areq.base   = base_value;
    areq.offs   = $signed({1'b0, offset_now}) - $signed({2'b0, radius_store[current_var]});
    areq.step   = (state == S_SCALE) ? step_now[idx] : step_now[current_var];
    areq.factor = factor_store[idx];
  end

  // output beat, candidate taken straight from the held multiplier result
  always_comb begin
    strobe      = (state == S_EMIT);
    kind        = final_out;
    elem_index  = 3'(idx);
    elem_value  = (!final_out && idx == current_var) ? ares : point[idx];
    best_so_far = best_objective;
    last        = (idx == VAR_W'(NUM_VARS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      scaling_rounds <= 8'd0;
      running        <= 1'b0;
      best_objective <= NONE_BEST;
      base_value     <= 32'd0;
      offset_now     <= 6'd0;
      current_var    <= '0;
      improved_flag  <= 1'b0;
      rounds_done    <= 8'd0;
      idx            <= '0;
      final_out      <= 1'b0;
      for (int k = 0; k < NUM_VARS; k++) begin
        point[k]        <= 32'd0;
        step_init[k]    <= 31'd0;
        step_now[k]     <= 31'd0;
        radius_store[k] <= 5'd0;
        factor_store[k] <= 16'd0;
      end
    end else begin
      if (cfg_we) begin
        scaling_rounds <= cfg_data;
      end
      case (state)
        // take a beat
        S_IDLE: begin
          if (accept) begin
            obj_hold <= objective;
            case (req_type)
              REQ_LOAD: begin
                if (!running && {1'b0, var_index} < 4'(NUM_VARS)) begin
                  point[VAR_W'(var_index)]     <= start_value;
                  step_init[VAR_W'(var_index)] <= max_step;
                  radius_store[VAR_W'(var_index)] <= (radius > 5'(MAX_RADIUS)) ?
                                                     5'(MAX_RADIUS) : radius;
                  factor_store[VAR_W'(var_index)] <= shrink_factor;
                end
              end
              REQ_START: begin
                if (!running) begin
                  for (int k = 0; k < NUM_VARS; k++) begin
                    step_now[k] <= step_init[k];
                  end
                  best_objective <= NONE_BEST;
                  rounds_done    <= 8'd0;
                  current_var    <= '0;
                  offset_now     <= 6'd0;
                  improved_flag  <= 1'b0;
                  base_value     <= point[0];
                  running        <= 1'b1;
                  state          <= S_CAND;
                end
              end
              REQ_REPLY: begin
                if (running) begin
                  state <= S_WAITJ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        // the multiplier now computes the current candidate again
        S_WAITJ: begin
          state <= S_JUDGE;
        end
        // judge reply and advance grid position
        S_JUDGE: begin
          idx <= '0;
          if (better) begin
            best_objective     <= obj_ext;
            point[current_var] <= ares;
          end
          if ({1'b0, offset_now} + 7'd1 > {1'b0, radius_store[current_var], 1'b0}) begin
            offset_now <= 6'd0;
            if (current_var == VAR_W'(NUM_VARS - 1)) begin
              current_var   <= '0;
              improved_flag <= 1'b0;
              if (improved_flag || better) begin
                state <= S_CAND;
              end else if (rounds_done >= scaling_rounds) begin
                running   <= 1'b0;
                final_out <= 1'b1;
                state     <= S_EMIT;
              end else begin
                rounds_done <= rounds_done + 8'd1;
                state       <= S_SCALE;
              end
            end else begin
              current_var <= current_var + VAR_W'(1);
              if (better) begin
                improved_flag <= 1'b1;
              end
              state <= S_CAND;
            end
          end else begin
            offset_now <= offset_now + 6'd1;
            if (better) begin
              improved_flag <= 1'b1;
            end
            state <= S_CAND;
          end
        end
        // shrink the steps one at a time through the shared multiplier, final_out marking the result phase
        S_SCALE: begin
          if (final_out) begin
            step_now[idx] <= ares[30:0];
            final_out     <= 1'b0;
            if (idx == VAR_W'(NUM_VARS - 1)) begin
              idx   <= '0;
              state <= S_CAND;
            end else begin
              idx <= idx + VAR_W'(1);
            end
          end else begin
            final_out <= 1'b1;
          end
        end
        // latch base on a new variable and start candidate multiply
        S_CAND: begin
          if (offset_now == 6'd0) begin
            base_value <= point[current_var];
          end
          idx        <= '0;
          final_out  <= 1'b0;
          state      <= S_WAITC;
        end
        S_WAITC: begin
          state <= S_EMIT;
        end
        // stream vector one element per cycle
        S_EMIT: begin
          if (idx == VAR_W'(NUM_VARS - 1)) begin
            idx       <= '0;
            final_out <= 1'b0;
            state     <= S_IDLE;
          end else begin
            idx <= idx + VAR_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[dv/tb_top.sv]
// testbench for the grid pattern search controller top level
// drives command beats, predicts every result element and checks each one; needs gpsc_pkg
`timescale 1ns / 1ps

module tb_top;
  import gpsc_pkg::*;

  localparam logic [1:0] REQ_BAD = 2'd3;
  localparam int SETTLE = 24;
  localparam int PEND_DEPTH = 16;

  typedef struct {
    logic               kind;
    logic [2:0]         idx;
    logic signed [31:0] val;
    logic signed [32:0] best;
    logic               last;
  } elem_t;

  typedef struct {
    logic [1:0]  req;
    logic [2:0]  idx;
    logic [31:0] sval;
    logic [30:0] stp;
    logic [4:0]  rad;
    logic [15:0] fac;
    logic [31:0] obj;
    int          exp_n;
  } cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type = '0;
  logic [2:0] var_index = '0;
  logic signed [31:0] start_value = '0;
  logic [30:0] max_step = '0;
  logic [4:0] radius = '0;
  logic [15:0] shrink_factor = '0;
  logic signed [31:0] objective = '0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;
  logic strobe, kind, last;
  logic [2:0] elem_index;
  logic signed [31:0] elem_value;
  logic signed [32:0] best_so_far;

  grid_pattern_search_controller_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .var_index(var_index), .start_value(start_value), .max_step(max_step),
    .radius(radius), .shrink_factor(shrink_factor), .objective(objective),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .strobe(strobe), .kind(kind),
    .elem_index(elem_index), .elem_value(elem_value), .best_so_far(best_so_far),
    .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // search state mirror
  logic signed [31:0] pt [NUM_VARS];
  logic [30:0] step_first [NUM_VARS];
  logic [30:0] step_cur [NUM_VARS];
  logic [4:0] rad_st [NUM_VARS];
  logic [15:0] fac_st [NUM_VARS];
  logic signed [31:0] base_v;
  int offs, cur_var, rounds;
  bit improved, searching;
  logic signed [32:0] best_obj;
  logic [7:0] rounds_limit;

  // ring of expected result elements
  elem_t pend_buf [PEND_DEPTH];
  int pend_wr = 0;
  int pend_rd = 0;
  int errors = 0;
  int idle_pct = 0;

  function automatic logic signed [31:0] grid_point();
    longint j, v;
    j = longint'(offs) - longint'(rad_st[cur_var]);
    v = longint'(base_v) + j * longint'(step_cur[cur_var]);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic int queue_vector(logic k, bit with_cand);
    elem_t e;
    logic signed [31:0] c;
    c = with_cand ? grid_point() : '0;
    for (int i = 0; i < NUM_VARS; i++) begin
      e.kind = k;
      e.idx  = i[2:0];
      e.val  = (with_cand && i == cur_var) ? c : pt[i];
      e.best = best_obj;
      e.last = (i == NUM_VARS - 1);
      pend_buf[pend_wr % PEND_DEPTH] = e;
      pend_wr++;
    end
    return NUM_VARS;
  endfunction

  // advance the search model by one accepted beat, queue its result elements
  function automatic int advance_search(cmd_t c);
    longint o;
    logic [63:0] prod;
    case (c.req)
      REQ_LOAD: begin
        if (searching || c.idx >= NUM_VARS) return 0;
        pt[c.idx] = c.sval;
        step_first[c.idx] = c.stp;
        rad_st[c.idx] = (c.rad > MAX_RADIUS) ? 5'(MAX_RADIUS) : c.rad;
        fac_st[c.idx] = c.fac;
        return 0;
      end
      REQ_START: begin
        if (searching) return 0;
        for (int i = 0; i < NUM_VARS; i++) step_cur[i] = step_first[i];
        best_obj = NONE_BEST;
        rounds = 0;
        cur_var = 0;
        offs = 0;
        improved = 0;
        base_v = pt[0];
        searching = 1;
        return queue_vector(1'b0, 1);
      end
      REQ_REPLY: begin
        if (!searching) return 0;
        o = longint'($signed(c.obj));
        if (o < longint'(best_obj)) begin
          best_obj = 33'(o);
          improved = 1;
          pt[cur_var] = grid_point();
        end
        if (offs + 1 > 2 * rad_st[cur_var]) begin
          offs = 0;
          cur_var++;
          if (cur_var >= NUM_VARS) begin
            cur_var = 0;
            if (improved) begin
              improved = 0;
            end else if (rounds >= rounds_limit) begin
              searching = 0;
              return queue_vector(1'b1, 0);
            end else begin
              rounds++;
              for (int i = 0; i < NUM_VARS; i++) begin
                prod = 64'(step_cur[i]) * 64'(fac_st[i]);
                step_cur[i] = prod[46:16];
              end
            end
          end
          base_v = pt[cur_var];
        end else begin
          offs++;
        end
        return queue_vector(1'b0, 1);
      end
      default: return 0;
    endcase
  endfunction

  // result checker: every strobed element against the oldest expectation
  always @(posedge clk) begin
    elem_t e;
    if (!rst && strobe) begin
      if (pend_wr == pend_rd) begin
        errors++;
        $display("%0t: unexpected element idx=%0d val=%0h", $time, elem_index, elem_value);
      end else begin
        e = pend_buf[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (kind !== e.kind || elem_index !== e.idx || elem_value !== e.val ||
            best_so_far !== e.best || last !== e.last) begin
          errors++;
          $display("%0t: mismatch exp kind=%0b idx=%0d val=%0h best=%0h last=%0b",
                   $time, e.kind, e.idx, e.val, e.best, e.last);
          $display("%0t:          got kind=%0b idx=%0d val=%0h best=%0h last=%0b",
                   $time, kind, elem_index, elem_value, best_so_far, last);
        end
      end
    end
  end

  // one command beat, sometimes with a random gap ahead of it
  task automatic send_beat(cmd_t c);
    int n;
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    start <= 1'b1;
    req_type <= c.req;
    var_index <= c.idx;
    start_value <= c.sval;
    max_step <= c.stp;
    radius <= c.rad;
    shrink_factor <= c.fac;
    objective <= c.obj;
    @(posedge clk);
    while (busy) @(posedge clk);
    n = advance_search(c);
    if (c.exp_n >= 0 && n != c.exp_n) begin
      errors++;
      $display("%0t: beat req=%0d exp %0d elements, predicted %0d", $time, c.req, c.exp_n, n);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pend_wr != pend_rd) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_rounds(logic [7:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    rounds_limit = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic cmd_t rand_cmd(logic [1:0] r);
    cmd_t c;
    c.req = r;
    c.idx = 3'($urandom_range(7));
    c.sval = $urandom;
    c.stp = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(32'h4_0000));
    c.rad = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(3));
    c.fac = 16'($urandom);
    c.obj = ($urandom_range(9) == 0) ?
            {1'($urandom_range(1)), 31'($urandom_range(1) * 32'h7fff_ffff)} : $urandom;
    c.exp_n = -1;
    return c;
  endfunction

  cmd_t plan [] = '{
    '{REQ_LOAD,  3'd0, 32'h7fff_ffff, 31'h7fff_ffff, 5'd31, 16'hffff, 32'h0, 0},
    '{REQ_LOAD,  3'd1, 32'h8000_0000, 31'h0,         5'd0,  16'h0001, 32'h0, 0},
    '{REQ_LOAD,  3'd2, 32'h8000_0000, 31'h7fff_ffff, 5'd1,  16'h0000, 32'h0, 0},
    '{REQ_LOAD,  3'd3, 32'h0001_0000, 31'h0000_8000, 5'd16, 16'h8000, 32'h0, 0},
    '{REQ_LOAD,  3'd7, 32'hffff_ffff, 31'h1234_5678, 5'd3,  16'h1234, 32'h0, 0},
    '{REQ_BAD,   3'd0, 32'h0,         31'h0,         5'd0,  16'h0,    32'h0, 0},
    '{REQ_REPLY, 3'd0, 32'h0,         31'h0,         5'd0,  16'h0,    32'h0, 0},
    '{REQ_START, 3'd0, 32'h0,         31'h0,         5'd0,  16'h0,    32'h0, 4},
    '{REQ_LOAD,  3'd0, 32'h0,         31'h0,         5'd0,  16'h0,    32'h0, 0},
    '{REQ_START, 3'd0, 32'h0,         31'h0,         5'd0,  16'h0,    32'h0, 0},
    '{REQ_BAD,   3'd0, 32'h0,         31'h0,         5'd0,  16'h0,    32'h0, 0},
    '{REQ_REPLY, 3'd0, 32'h0,         31'h0,         5'd0,  16'h0,    32'h7fff_ffff, 4},
    '{REQ_REPLY, 3'd0, 32'h0,         31'h0,         5'd0,  16'h0,    32'h8000_0000, 4},
    '{REQ_REPLY, 3'd0, 32'h0,         31'h0,         5'd0,  16'h0,    32'h8000_0000, 4},
    '{REQ_REPLY, 3'd0, 32'h0,         31'h0,         5'd0,  16'h0,    32'h0, 4}
  };

  initial begin
    cmd_t c;
    int beats, sess;
    bit long_run;
    for (int i = 0; i < NUM_VARS; i++) begin
      pt[i] = '0; step_first[i] = '0; step_cur[i] = '0; rad_st[i] = '0; fac_st[i] = '0;
    end
    base_v = '0; offs = 0; cur_var = 0; rounds = 0; improved = 0; searching = 0;
    best_obj = NONE_BEST; rounds_limit = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed beats
    beats = 0;
    write_rounds(8'd0);
    foreach (plan[i]) send_beat(plan[i]);
    while (searching) begin
      send_beat(rand_cmd(REQ_REPLY));
      beats++;
    end

    // random search sessions, idling rate stepped per session
    sess = 0;
    while (beats < 500) begin
      case (sess % 4)
        0: idle_pct = 0;
        1: idle_pct = 65;
        2: idle_pct = 0;
        default: idle_pct = 33;
      endcase
      long_run = (sess == 1);
      write_rounds(long_run ? 8'd40 : (sess == 2) ? 8'd0 : 8'($urandom_range(3)));
      for (int i = 0; i < NUM_VARS + 2; i++) begin
        c = rand_cmd(REQ_LOAD);
        if (i < NUM_VARS) c.idx = i[2:0];
        if (long_run) c.rad = '0;
        send_beat(c);
      end
      if ($urandom_range(1)) send_beat(rand_cmd($urandom_range(1) ? REQ_BAD : REQ_REPLY));
      send_beat(rand_cmd(REQ_START));
      beats++;
      while (searching) begin
        if ($urandom_range(9) == 0) begin
          send_beat(rand_cmd(2'($urandom_range(3) == 2 ? 3 : $urandom_range(3))));
        end else begin
          c = rand_cmd(REQ_REPLY);
          if (long_run) c.obj = 32'h7fff_ffff;
          send_beat(c);
          beats++;
        end
      end
      sess++;
    end
    wait_idle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
